>>> sv/ssd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ssd_pkg: shared definitions for the seven-segment shift display driver
// segment codes, command codes, state type and the serializer handshake types
// ----------------------------------------------------------------------------
package ssd_pkg;

  localparam int DIGIT_COUNT_DEF = 4;

  // command codes carried on in_tuser
  localparam logic [2:0] MODE_SET_DIGIT  = 3'd0;
  localparam logic [2:0] MODE_SET_LETTER = 3'd1;
  localparam logic [2:0] MODE_SHOW_INT   = 3'd2;
  localparam logic [2:0] MODE_POINT_ON   = 3'd3;
  localparam logic [2:0] MODE_POINT_OFF  = 3'd4;
  localparam logic [2:0] MODE_BLANK_ALL  = 3'd5;
  localparam logic [2:0] MODE_REFRESH    = 3'd6;

  localparam logic [7:0] SEG_DASH  = 8'hBF;
  localparam logic [7:0] SEG_BLANK = 8'hFF;
  localparam logic [7:0] POINT_BIT = 8'h80;
  localparam logic [4:0] CODE_DASH = 5'd16;

  localparam logic [7:0] ASCII_A    = 8'h41;
  localparam logic [7:0] ASCII_F    = 8'h46;
  localparam logic [7:0] ASCII_DASH = 8'h2D;

  // reciprocal of ten for values below 43690
  localparam int RECIP_TEN = 52429;
  localparam int RECIP_SHIFT = 19;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_SIGN,
    ST_START,
    ST_WAIT
  } ssd_state_t;

  typedef struct packed {
    logic start;
  } ssd_ser_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } ssd_ser_stat_t;

  // active-low common-anode segment codes, hex digits then dash
  function automatic logic [7:0] seg_code(input logic [4:0] code);
    logic [7:0] seg;
    case (code)
      5'd0:    seg = 8'hC0;
      5'd1:    seg = 8'hF9;
      5'd2:    seg = 8'hA4;
      5'd3:    seg = 8'hB0;
      5'd4:    seg = 8'h99;
      5'd5:    seg = 8'h92;
      5'd6:    seg = 8'h82;
      5'd7:    seg = 8'hF8;
      5'd8:    seg = 8'h80;
      5'd9:    seg = 8'h90;
      5'd10:   seg = 8'h88;
      5'd11:   seg = 8'h83;
      5'd12:   seg = 8'hC6;
      5'd13:   seg = 8'hA1;
      5'd14:   seg = 8'h86;
      5'd15:   seg = 8'h8E;
      default: seg = SEG_DASH;
    endcase
    return seg;
  endfunction

endpackage
`default_nettype wire

>>> sv/seven_segment_shift_display.sv
`default_nettype none
// ----------------------------------------------------------------------------
// seven_segment_shift_display: four-digit display driver for chained
// shift registers
// keeps one segment byte per digit and streams refresh frames bit by bit
// ----------------------------------------------------------------------------
//  channel | dir | tdata                                      | tuser      | tlast
//  in_     | in  | place, digit_code, letter, number (32 bit) | mode       | -
//  out_    | out | serial_data (8 bit, bit 0)                 | latch_pulse| last
//
//  set digit, set letter and point commands update the store without leaving idle
//  refresh and blank all send 16 x DIGIT_COUNT output beats
//  show integer first converts its places, a divide-by-ten step each, then
//  adds a minus sign if negative; the output shift register sets the beat rate
//  rst_n blanks all digits; a stall on out_tready holds the current bit
// ----------------------------------------------------------------------------
module seven_segment_shift_display #(
  parameter int DIGIT_COUNT = ssd_pkg::DIGIT_COUNT_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // place[1:0], digit_code[6:2], letter[14:7], number[29:15], zero fill
  input  wire logic [31:0] in_tdata,
  // mode[2:0]
  input  wire logic [2:0]  in_tuser,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // serial_data[0], zero fill
  output logic [7:0]       out_tdata,
  // latch_pulse[0]
  output logic             out_tuser,
  output logic             out_tlast
);

  localparam int DIGIT_W   = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;
  localparam int TOP_VALUE = 10 ** DIGIT_COUNT - 1;
  localparam int LOW_VALUE = -(10 ** (DIGIT_COUNT - 1) - 1);

  // input fields
  logic [2:0]         mode;
  logic [1:0]         place;
  logic [4:0]         digit_code;
  logic [7:0]         letter;
  logic signed [14:0] number;

  assign mode       = in_tuser;
  assign place      = in_tdata[1:0];
  assign digit_code = in_tdata[6:2];
  assign letter     = in_tdata[14:7];
  assign number     = in_tdata[29:15];

  ssd_pkg::ssd_state_t state_r, state_nxt;

  logic [7:0]         store_r [DIGIT_COUNT];
  logic [13:0]        mag_r;
  logic [DIGIT_W-1:0] pos_r;
  logic               neg_r;

  logic               accept;
  logic               place_ok;
  logic signed [14:0] number_sat;
  logic [14:0]        number_neg;
  logic [13:0]        mag_in;
  logic [29:0]        prod;
  logic [13:0]        quot;
  logic [3:0]         rem;
  logic               conv_last;

  // store write strobes
  logic               wr_en;
  logic [DIGIT_W-1:0] wr_addr;
  logic [7:0]         wr_data;
  logic [7:0]         wr_mask;
  logic               blank_all;

  ssd_pkg::ssd_ser_ctrl_t ser_ctrl;
  ssd_pkg::ssd_ser_stat_t ser_stat;

  assign in_tready = (state_r == ssd_pkg::ST_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign place_ok  = (32'(place) < DIGIT_COUNT);

  // saturate, then take the magnitude
  always_comb begin
    if (number > 15'(TOP_VALUE)) begin
      number_sat = 15'(TOP_VALUE);
    end else if (number < 15'(LOW_VALUE)) begin
      number_sat = 15'(LOW_VALUE);
    end else begin
      number_sat = number;
    end
    number_neg = -number_sat;
    mag_in     = number_sat[14] ? number_neg[13:0] : number_sat[13:0];
  end

  // one decimal place per cycle by reciprocal multiply
  assign prod      = mag_r * 16'(ssd_pkg::RECIP_TEN);
  assign quot      = {3'b000, prod[29:ssd_pkg::RECIP_SHIFT]};
  assign rem       = 4'(mag_r - 14'(quot * 14'd10));
  assign conv_last = (quot == '0) || (pos_r == '0);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ssd_pkg::ST_IDLE: begin
        if (accept) begin
          case (mode) inside
            ssd_pkg::MODE_SHOW_INT: state_nxt = ssd_pkg::ST_CONV;
            ssd_pkg::MODE_BLANK_ALL,
            ssd_pkg::MODE_REFRESH:  state_nxt = ssd_pkg::ST_START;
            default:                state_nxt = ssd_pkg::ST_IDLE;
          endcase
        end
      end
      ssd_pkg::ST_CONV: begin
        if (conv_last) begin
          state_nxt = (neg_r && pos_r != '0) ? ssd_pkg::ST_SIGN : ssd_pkg::ST_START;
        end
      end
      ssd_pkg::ST_SIGN:  state_nxt = ssd_pkg::ST_START;
      ssd_pkg::ST_START: state_nxt = ssd_pkg::ST_WAIT;
      ssd_pkg::ST_WAIT: begin
        if (ser_stat.done) begin
          state_nxt = ssd_pkg::ST_IDLE;
        end
      end
      default: state_nxt = ssd_pkg::ST_IDLE;
    endcase
  end

  // outputs of the state machine: store writes and serializer start
  always_comb begin
    wr_en          = 1'b0;
    wr_addr        = place[DIGIT_W-1:0];
    wr_data        = ssd_pkg::SEG_BLANK;
    wr_mask        = 8'hFF;
    blank_all      = 1'b0;
    ser_ctrl.start = 1'b0;
    unique case (state_r)
      ssd_pkg::ST_IDLE: begin
        if (accept) begin
          case (mode)
            ssd_pkg::MODE_SET_DIGIT: begin
              wr_en   = place_ok && (digit_code <= ssd_pkg::CODE_DASH);
              wr_data = ssd_pkg::seg_code(digit_code);
            end
            ssd_pkg::MODE_SET_LETTER: begin
              if (letter >= ssd_pkg::ASCII_A && letter <= ssd_pkg::ASCII_F) begin
                wr_en   = place_ok;
                wr_data = ssd_pkg::seg_code(5'(letter - ssd_pkg::ASCII_A) + 5'd10);
              end else if (letter == ssd_pkg::ASCII_DASH) begin
                wr_en   = place_ok;
                wr_data = ssd_pkg::SEG_DASH;
              end
            end
            ssd_pkg::MODE_POINT_ON: begin
              wr_en   = place_ok;
              wr_mask = ssd_pkg::POINT_BIT;
              wr_data = 8'h00;
            end
            ssd_pkg::MODE_POINT_OFF: begin
              wr_en   = place_ok;
              wr_mask = ssd_pkg::POINT_BIT;
              wr_data = ssd_pkg::POINT_BIT;
            end
            ssd_pkg::MODE_BLANK_ALL: blank_all = 1'b1;
            default: ;
          endcase
        end
      end
      ssd_pkg::ST_CONV: begin
        wr_en   = 1'b1;
        wr_addr = pos_r;
        wr_data = ssd_pkg::seg_code({1'b0, rem});
      end
      ssd_pkg::ST_SIGN: begin
        wr_en   = 1'b1;
        wr_addr = pos_r;
        wr_data = ssd_pkg::SEG_DASH;
      end
      ssd_pkg::ST_START: ser_ctrl.start = 1'b1;
      ssd_pkg::ST_WAIT:  ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ssd_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // conversion registers
  always_ff @(posedge clk) begin
    if (accept) begin
      mag_r <= mag_in;
      neg_r <= number_sat[14];
      pos_r <= DIGIT_W'(DIGIT_COUNT - 1);
    end else if (state_r == ssd_pkg::ST_CONV) begin
      mag_r <= quot;
      pos_r <= pos_r - 1'b1;
    end
  end

  // segment store, the addressed entry updated under the write bit mask
  always_ff @(posedge clk) begin
    for (int i = 0; i < DIGIT_COUNT; i++) begin
      if (!rst_n || blank_all) begin
        store_r[i] <= ssd_pkg::SEG_BLANK;
      end else if (wr_en && wr_addr == DIGIT_W'(i)) begin
        store_r[i] <= (store_r[i] & ~wr_mask) | (wr_data & wr_mask);
      end
    end
  end

  logic ser_bit;

  ssd_serializer #(
    .DIGIT_COUNT (DIGIT_COUNT),
    .DIGIT_W     (DIGIT_W)
  ) u_serializer (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (ser_ctrl),
    .stat      (ser_stat),
    .store     (store_r),
    .bit_valid (out_tvalid),
    .bit_ready (out_tready),
    .bit_data  (ser_bit),
    .bit_latch (out_tuser),
    .bit_last  (out_tlast)
  );

  assign out_tdata = {7'b0000000, ser_bit};

`ifndef SYNTHESIS
  // no command is taken while a refresh run is still on the output
  a_ready_idle_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !out_tvalid)
    else $error("input ready while output run active");

  // the run ends on a latch beat
  a_last_latch: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tuser)
    else $error("last beat without latch");

  // the run stops after its final beat
  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && out_tlast |=> !out_tvalid)
    else $error("output continues after last beat");

  // conversion only runs while the serializer is quiet
  a_conv_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ssd_pkg::ST_CONV || state_r == ssd_pkg::ST_SIGN) |-> !ser_stat.busy)
    else $error("store written during serialization");
`endif

endmodule
`default_nettype wire

>>> sv/ssd_serializer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ssd_serializer: bit-serial frame shifter
// shifts each digit frame (segment byte, then select byte) out msb first
// ----------------------------------------------------------------------------
module ssd_serializer #(
  parameter int DIGIT_COUNT = ssd_pkg::DIGIT_COUNT_DEF,
  parameter int DIGIT_W = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire ssd_pkg::ssd_ser_ctrl_t ctrl,
  output ssd_pkg::ssd_ser_stat_t     stat,
  input  wire logic [7:0]            store [DIGIT_COUNT],
  output logic                       bit_valid,
  input  wire logic                  bit_ready,
  output logic                       bit_data,
  output logic                       bit_latch,
  output logic                       bit_last
);

  logic               valid_r, valid_nxt;
  logic [DIGIT_W-1:0] digit_r, digit_nxt;
  logic [3:0]         count_r, count_nxt;
  logic [15:0]        shift_r, shift_nxt;
  logic [DIGIT_W-1:0] load_idx;
  logic [15:0]        load_frame;
  logic               beat;

  assign beat      = valid_r && bit_ready;
  assign bit_valid = valid_r;
  assign bit_data  = shift_r[15];
  assign bit_latch = (count_r == 4'd15);
  assign bit_last  = bit_latch && (digit_r == DIGIT_W'(DIGIT_COUNT - 1));

  assign stat.busy = valid_r;
  assign stat.done = beat && bit_last;

  assign load_idx   = ctrl.start ? '0 : DIGIT_W'(digit_r + 1'b1);
  assign load_frame = {store[load_idx], 8'd1 << load_idx};

  always_comb begin
    valid_nxt = valid_r;
    digit_nxt = digit_r;
    count_nxt = count_r;
    shift_nxt = shift_r;
    if (ctrl.start) begin
      valid_nxt = 1'b1;
      digit_nxt = '0;
      count_nxt = '0;
      shift_nxt = load_frame;
    end else if (beat) begin
      if (bit_last) begin
        valid_nxt = 1'b0;
      end else if (bit_latch) begin
        digit_nxt = load_idx;
        count_nxt = '0;
        shift_nxt = load_frame;
      end else begin
        count_nxt = count_r + 4'd1;
        shift_nxt = {shift_r[14:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      digit_r <= '0;
      count_r <= '0;
    end else begin
      valid_r <= valid_nxt;
      digit_r <= digit_nxt;
      count_r <= count_nxt;
    end
    shift_r <= shift_nxt;
  end

endmodule
`default_nettype wire
